// ===== hdl/klp_pkg.sv =====
package klp_pkg;

  localparam int unsigned MAX_KEYS_DEF = 16;
  localparam int unsigned CHANNELS_DEF = 8;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned KIDX_W   = 4;
  localparam int unsigned CIDX_W   = 3;
  localparam int unsigned KCNT_W   = 5;
  localparam int unsigned TIME_W   = 16;
  localparam int unsigned VALUE_W  = 16;
  localparam int unsigned CHAN_W   = 3;
  localparam int unsigned FRAC_W   = 17;
  localparam int unsigned PROD_W   = VALUE_W + FRAC_W + 2;
  localparam int unsigned DIV_CNT_W = $clog2(FRAC_W);

  localparam int unsigned S_DATA_W = 56;
  localparam int unsigned M_DATA_W = 40;

  localparam logic [FRAC_W-1:0] FRAC_ONE  = FRAC_W'(1) << (FRAC_W - 1);
  localparam logic [PROD_W-1:0] FRAC_HALF = PROD_W'(1) << (FRAC_W - 2);

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_TIME  = 3'd0,
    OP_LOAD_VALUE = 3'd1,
    OP_START      = 3'd2,
    OP_TICK       = 3'd3,
    OP_FINISH     = 3'd4
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GOT_HI,
    ST_GOT_LO,
    ST_SCAN,
    ST_DIV_WAIT,
    ST_CH_RD,
    ST_CH_MUL,
    ST_CH_OUT
  } st_e;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [KIDX_W-1:0]  key_index;
    logic [CIDX_W-1:0]  channel_index;
    logic [TIME_W-1:0]  key_time;
    logic [VALUE_W-1:0] channel_value;
    logic [TIME_W-1:0]  delta_time;
  } in_item_t;

  typedef struct packed {
    logic [TIME_W-1:0]  time_now;
    logic [CHAN_W-1:0]  channel;
    logic [VALUE_W-1:0] value;
    logic               playing;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] num;
    logic [TIME_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [FRAC_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== hdl/klp_store.sv =====
module klp_store #(
  parameter int unsigned MAX_KEYS = klp_pkg::MAX_KEYS_DEF,
  parameter int unsigned CHANNELS = klp_pkg::CHANNELS_DEF,
  localparam int unsigned KIW = $clog2(MAX_KEYS),
  localparam int unsigned VAW = $clog2(MAX_KEYS * CHANNELS)
) (
  input  logic                        clk_i,
  input  logic                        kt_we_i,
  input  logic [KIW-1:0]              kt_waddr_i,
  input  logic [klp_pkg::TIME_W-1:0]  kt_wdata_i,
  input  logic [KIW-1:0]              kt_raddr_i,
  output logic [klp_pkg::TIME_W-1:0]  kt_rdata_o,
  input  logic                        kv_we_i,
  input  logic [VAW-1:0]              kv_waddr_i,
  input  logic [klp_pkg::VALUE_W-1:0] kv_wdata_i,
  input  logic [VAW-1:0]              kv_raddr_a_i,
  input  logic [VAW-1:0]              kv_raddr_b_i,
  output logic [klp_pkg::VALUE_W-1:0] kv_rdata_a_o,
  output logic [klp_pkg::VALUE_W-1:0] kv_rdata_b_o
);
  import klp_pkg::*;

  logic [TIME_W-1:0]  kt_mem [MAX_KEYS];
  logic [VALUE_W-1:0] kv_mem [MAX_KEYS * CHANNELS];
  logic [TIME_W-1:0]  kt_rdata_q;
  logic [VALUE_W-1:0] kv_rdata_a_q;
  logic [VALUE_W-1:0] kv_rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (kt_we_i) begin
      kt_mem[kt_waddr_i] <= kt_wdata_i;
    end
    kt_rdata_q <= kt_mem[kt_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (kv_we_i) begin
      kv_mem[kv_waddr_i] <= kv_wdata_i;
    end
    kv_rdata_a_q <= kv_mem[kv_raddr_a_i];
    kv_rdata_b_q <= kv_mem[kv_raddr_b_i];
  end

  assign kt_rdata_o   = kt_rdata_q;
  assign kv_rdata_a_o = kv_rdata_a_q;
  assign kv_rdata_b_o = kv_rdata_b_q;

endmodule

// ===== hdl/klp_div.sv =====
module klp_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  klp_pkg::div_req_t req_i,
  output klp_pkg::div_rsp_t rsp_o
);
  import klp_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [TIME_W-1:0]    rem_q, rem_d;
  logic [TIME_W-1:0]    den_q, den_d;
  logic [FRAC_W-1:0]    quot_q, quot_d;
  logic                 lsb_q, lsb_d;
  logic [TIME_W:0]      trial;
  logic [TIME_W:0]      diff;

  // The numerator never exceeds the divisor, so the quotient fits in FRAC_W
  // bits and the remainder can start from the numerator's upper bits.
  assign trial = {rem_q, lsb_q};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    lsb_d  = lsb_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(FRAC_W - 1);
      rem_d  = req_i.num >> 1;
      lsb_d  = req_i.num[0];
      den_d  = req_i.den;
    end else if (busy_q) begin
      lsb_d = 1'b0;
      if (trial >= {1'b0, den_q}) begin
        rem_d  = diff[TIME_W-1:0];
        quot_d = {quot_q[FRAC_W-2:0], 1'b1};
      end else begin
        rem_d  = trial[TIME_W-1:0];
        quot_d = {quot_q[FRAC_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
    lsb_q  <= lsb_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

// ===== hdl/klp_ctrl.sv =====
module klp_ctrl #(
  parameter int unsigned MAX_KEYS = klp_pkg::MAX_KEYS_DEF,
  parameter int unsigned CHANNELS = klp_pkg::CHANNELS_DEF,
  localparam int unsigned KIW = $clog2(MAX_KEYS),
  localparam int unsigned VAW = $clog2(MAX_KEYS * CHANNELS)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [klp_pkg::KCNT_W-1:0]  key_count_i,
  input  logic                        s_valid_i,
  output logic                        s_ready_o,
  input  klp_pkg::in_item_t           s_item_i,
  output logic                        m_valid_o,
  input  logic                        m_ready_i,
  output klp_pkg::out_item_t          m_item_o,
  output logic                        kt_we_o,
  output logic [KIW-1:0]              kt_waddr_o,
  output logic [klp_pkg::TIME_W-1:0]  kt_wdata_o,
  output logic [KIW-1:0]              kt_raddr_o,
  input  logic [klp_pkg::TIME_W-1:0]  kt_rdata_i,
  output logic                        kv_we_o,
  output logic [VAW-1:0]              kv_waddr_o,
  output logic [klp_pkg::VALUE_W-1:0] kv_wdata_o,
  output logic [VAW-1:0]              kv_raddr_a_o,
  output logic [VAW-1:0]              kv_raddr_b_o,
  input  logic [klp_pkg::VALUE_W-1:0] kv_rdata_a_i,
  input  logic [klp_pkg::VALUE_W-1:0] kv_rdata_b_i,
  output klp_pkg::div_req_t           div_req_o,
  input  klp_pkg::div_rsp_t           div_rsp_i
);
  import klp_pkg::*;

  localparam int unsigned CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  function automatic logic [VAW-1:0] row_base(input logic [KIW-1:0] k);
    return VAW'(32'(k) * CHANNELS);
  endfunction

  st_e                 st_q, st_d;
  op_e                 op_in;
  logic                is_finish_q, is_finish_d;
  logic [TIME_W-1:0]   delta_q, delta_d;
  logic [TIME_W-1:0]   elapsed_q, elapsed_d;
  logic                playing_q, playing_d;
  logic [TIME_W-1:0]   hi_q, hi_d;
  logic [TIME_W-1:0]   pt_q, pt_d;
  logic [TIME_W-1:0]   t_q, t_d;
  logic [KIW-1:0]      i_q, i_d;
  logic [CW-1:0]       c_q, c_d;
  logic [FRAC_W-1:0]   frac_q, frac_d;
  logic [VAW-1:0]      base_a_q, base_a_d;
  logic [VAW-1:0]      base_b_q, base_b_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_q, out_d;

  logic [KIW-1:0]      nm1;
  logic                accept;
  logic                out_free;
  logic                c_last;
  logic [TIME_W:0]     sum_wide;
  logic [TIME_W-1:0]   sum_sat;
  logic [TIME_W-1:0]   t_clamp;
  logic signed [VALUE_W:0]   diff_s;
  logic signed [PROD_W-1:0]  rnd_s;
  logic signed [PROD_W-1:0]  full_s;

  // Index of the last key in use; the count saturates into the table size.
  always_comb begin
    if (key_count_i == '0) begin
      nm1 = '0;
    end else if (32'(key_count_i) > MAX_KEYS) begin
      nm1 = KIW'(MAX_KEYS - 1);
    end else begin
      nm1 = KIW'(key_count_i - KCNT_W'(1));
    end
  end

  assign op_in    = op_e'(s_item_i.op);
  assign accept   = s_valid_i && (st_q == ST_IDLE);
  assign out_free = !out_valid_q || m_ready_i;
  assign c_last   = (c_q == CW'(CHANNELS - 1));

  assign sum_wide = {1'b0, elapsed_q} + {1'b0, delta_q};
  assign sum_sat  = sum_wide[TIME_W] ? '1 : sum_wide[TIME_W-1:0];

  always_comb begin
    t_clamp = t_q;
    if (t_clamp < kt_rdata_i) begin
      t_clamp = kt_rdata_i;
    end
    if (t_clamp > hi_q) begin
      t_clamp = hi_q;
    end
  end

  // Shared lerp path: one multiply into a register, then round and add.
  assign diff_s = $signed({kv_rdata_b_i[VALUE_W-1], kv_rdata_b_i})
                - $signed({kv_rdata_a_i[VALUE_W-1], kv_rdata_a_i});
  assign rnd_s  = prod_q + $signed(FRAC_HALF);
  assign full_s = $signed({{(PROD_W - VALUE_W){kv_rdata_a_i[VALUE_W-1]}}, kv_rdata_a_i})
                + (rnd_s >>> (FRAC_W - 1));

  // Next state.
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: begin
        if (accept && (op_in == OP_TICK || op_in == OP_FINISH)) begin
          st_d = ST_GOT_HI;
        end
      end
      ST_GOT_HI: begin
        if (is_finish_q || !playing_q) begin
          st_d = ST_CH_RD;
        end else begin
          st_d = ST_GOT_LO;
        end
      end
      ST_GOT_LO: begin
        if (nm1 == '0) begin
          st_d = ST_CH_RD;
        end else begin
          st_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (t_q <= kt_rdata_i) begin
          if (kt_rdata_i > pt_q && t_q > pt_q) begin
            st_d = ST_DIV_WAIT;
          end else begin
            st_d = ST_CH_RD;
          end
        end else if (i_q == nm1) begin
          st_d = ST_CH_RD;
        end else begin
          st_d = ST_SCAN;
        end
      end
      ST_DIV_WAIT: begin
        if (div_rsp_i.done) begin
          st_d = ST_CH_RD;
        end
      end
      ST_CH_RD:  st_d = ST_CH_MUL;
      ST_CH_MUL: st_d = ST_CH_OUT;
      ST_CH_OUT: begin
        if (out_free) begin
          st_d = c_last ? ST_IDLE : ST_CH_RD;
        end
      end
      default:   st_d = ST_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    is_finish_d = is_finish_q;
    delta_d     = delta_q;
    elapsed_d   = elapsed_q;
    playing_d   = playing_q;
    hi_d        = hi_q;
    pt_d        = pt_q;
    t_d         = t_q;
    i_d         = i_q;
    c_d         = c_q;
    frac_d      = frac_q;
    base_a_d    = base_a_q;
    base_b_d    = base_b_q;
    prod_d      = prod_q;
    out_valid_d = out_valid_q && !m_ready_i;
    out_d       = out_q;
    kt_we_o     = 1'b0;
    kv_we_o     = 1'b0;
    kt_raddr_o  = '0;
    div_req_o.start = 1'b0;
    div_req_o.num   = t_q - pt_q;
    div_req_o.den   = kt_rdata_i - pt_q;

    unique case (st_q)
      ST_IDLE: begin
        kt_raddr_o  = nm1;
        is_finish_d = (op_in == OP_FINISH);
        delta_d     = s_item_i.delta_time;
        if (accept) begin
          case (op_in)
            OP_LOAD_TIME:  kt_we_o = (32'(s_item_i.key_index) < MAX_KEYS);
            OP_LOAD_VALUE: kv_we_o = (32'(s_item_i.key_index) < MAX_KEYS)
                                  && (32'(s_item_i.channel_index) < CHANNELS);
            OP_START: begin
              elapsed_d = '0;
              playing_d = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_GOT_HI: begin
        hi_d = kt_rdata_i;
        if (is_finish_q || !playing_q) begin
          // Hold on the last key: a lerp with a zero fraction from that row.
          if (is_finish_q) begin
            elapsed_d = kt_rdata_i;
          end
          playing_d = 1'b0;
          t_d       = kt_rdata_i;
          base_a_d  = row_base(nm1);
          base_b_d  = row_base(nm1);
          frac_d    = '0;
          c_d       = '0;
        end else begin
          if (sum_sat >= kt_rdata_i) begin
            playing_d = 1'b0;
            elapsed_d = kt_rdata_i;
            t_d       = kt_rdata_i;
          end else begin
            elapsed_d = sum_sat;
            t_d       = sum_sat;
          end
        end
      end
      ST_GOT_LO: begin
        kt_raddr_o = KIW'(1);
        if (nm1 == '0) begin
          t_d      = hi_q;
          base_a_d = row_base(nm1);
          base_b_d = row_base(nm1);
          frac_d   = '0;
          c_d      = '0;
        end else begin
          t_d  = t_clamp;
          pt_d = kt_rdata_i;
          i_d  = KIW'(1);
        end
      end
      ST_SCAN: begin
        kt_raddr_o = i_q + KIW'(1);
        if (t_q <= kt_rdata_i) begin
          base_a_d = row_base(i_q - KIW'(1));
          base_b_d = row_base(i_q);
          c_d      = '0;
          if (kt_rdata_i > pt_q) begin
            if (t_q > pt_q) begin
              div_req_o.start = 1'b1;
            end else begin
              frac_d = '0;
            end
          end else begin
            frac_d = FRAC_ONE;
          end
        end else if (i_q == nm1) begin
          // No later key at or after the time: emit the last key as it is.
          t_d      = hi_q;
          base_a_d = row_base(nm1);
          base_b_d = row_base(nm1);
          frac_d   = '0;
          c_d      = '0;
        end else begin
          pt_d = kt_rdata_i;
          i_d  = i_q + KIW'(1);
        end
      end
      ST_DIV_WAIT: begin
        if (div_rsp_i.done) begin
          frac_d = div_rsp_i.quot;
        end
      end
      ST_CH_RD: ;
      ST_CH_MUL: begin
        prod_d = diff_s * $signed({1'b0, frac_q});
      end
      ST_CH_OUT: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_d.time_now   = t_q;
          out_d.channel    = CHAN_W'(c_q);
          out_d.value      = full_s[VALUE_W-1:0];
          out_d.playing    = playing_q;
          out_d.last       = c_last;
          c_d              = c_q + CW'(1);
        end
      end
      default: ;
    endcase
  end

  assign kt_waddr_o   = KIW'(s_item_i.key_index);
  assign kt_wdata_o   = s_item_i.key_time;
  assign kv_waddr_o   = VAW'(32'(s_item_i.key_index) * CHANNELS
                           + 32'(s_item_i.channel_index));
  assign kv_wdata_o   = s_item_i.channel_value;
  assign kv_raddr_a_o = base_a_q + VAW'(c_q);
  assign kv_raddr_b_o = base_b_q + VAW'(c_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      elapsed_q   <= '0;
      playing_q   <= 1'b0;
      out_valid_q <= 1'b0;
      c_q         <= '0;
      i_q         <= '0;
    end else begin
      st_q        <= st_d;
      elapsed_q   <= elapsed_d;
      playing_q   <= playing_d;
      out_valid_q <= out_valid_d;
      c_q         <= c_d;
      i_q         <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_finish_q <= is_finish_d;
    delta_q     <= delta_d;
    hi_q        <= hi_d;
    pt_q        <= pt_d;
    t_q         <= t_d;
    frac_q      <= frac_d;
    base_a_q    <= base_a_d;
    base_b_q    <= base_b_d;
    prod_q      <= prod_d;
    out_q       <= out_d;
  end

  assign s_ready_o = (st_q == ST_IDLE);
  assign m_valid_o = out_valid_q;
  assign m_item_o  = out_q;

endmodule

// ===== hdl/keyframe_lerp_player.sv =====
// Channel   Dir  Fields (lowest bit first)
// s_axis    in   tuser: op; tdata: key_index, channel_index, key_time,
//                channel_value, delta_time
// m_axis    out  tuser: playing; tlast: last; tdata: time_now, channel, value
// cfg       in   cfg_wdata_i: key_count, written when cfg_we_i is high
//
// Loads and start complete when accepted. Finish, or a tick while stopped,
// reads the last key time, then emits every channel. A tick while playing
// reads the last and first key times, scans keys (the key-time port scans
// one key a cycle), runs the divider (one quotient bit a cycle, only when
// the segment needs a division), then emits every channel; the lerp
// multiplier serves one channel at a time. The input is not ready while a
// tick or finish is in progress; a stalled output holds the sequencer
// before its next channel. Reset clears only control state, not key tables.
module keyframe_lerp_player #(
  parameter int unsigned MAX_KEYS = klp_pkg::MAX_KEYS_DEF,
  parameter int unsigned CHANNELS = klp_pkg::CHANNELS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [klp_pkg::KCNT_W-1:0]   cfg_wdata_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // key_index, channel_index, key_time, channel_value, delta_time, zero pad
  input  logic [klp_pkg::S_DATA_W-1:0] s_axis_tdata,
  // op
  input  logic [klp_pkg::OP_W-1:0]     s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // time_now, channel, value, zero pad
  output logic [klp_pkg::M_DATA_W-1:0] m_axis_tdata,
  // playing
  output logic                         m_axis_tuser,
  output logic                         m_axis_tlast
);
  import klp_pkg::*;

  localparam int unsigned KIW = $clog2(MAX_KEYS);
  localparam int unsigned VAW = $clog2(MAX_KEYS * CHANNELS);

  logic [KCNT_W-1:0]  key_count_q;
  in_item_t           s_item;
  out_item_t          m_item;
  div_req_t           div_req;
  div_rsp_t           div_rsp;
  logic               kt_we;
  logic [KIW-1:0]     kt_waddr;
  logic [TIME_W-1:0]  kt_wdata;
  logic [KIW-1:0]     kt_raddr;
  logic [TIME_W-1:0]  kt_rdata;
  logic               kv_we;
  logic [VAW-1:0]     kv_waddr;
  logic [VALUE_W-1:0] kv_wdata;
  logic [VAW-1:0]     kv_raddr_a;
  logic [VAW-1:0]     kv_raddr_b;
  logic [VALUE_W-1:0] kv_rdata_a;
  logic [VALUE_W-1:0] kv_rdata_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= KCNT_W'(1);
    end else if (cfg_we_i) begin
      key_count_q <= cfg_wdata_i;
    end
  end

  assign s_item.op            = s_axis_tuser;
  assign s_item.key_index     = s_axis_tdata[3:0];
  assign s_item.channel_index = s_axis_tdata[6:4];
  assign s_item.key_time      = s_axis_tdata[22:7];
  assign s_item.channel_value = s_axis_tdata[38:23];
  assign s_item.delta_time    = s_axis_tdata[54:39];

  assign m_axis_tdata = {5'b0, m_item.value, m_item.channel, m_item.time_now};
  assign m_axis_tuser = m_item.playing;
  assign m_axis_tlast = m_item.last;

  klp_store #(
    .MAX_KEYS (MAX_KEYS),
    .CHANNELS (CHANNELS)
  ) u_store (
    .clk_i        (clk_i),
    .kt_we_i      (kt_we),
    .kt_waddr_i   (kt_waddr),
    .kt_wdata_i   (kt_wdata),
    .kt_raddr_i   (kt_raddr),
    .kt_rdata_o   (kt_rdata),
    .kv_we_i      (kv_we),
    .kv_waddr_i   (kv_waddr),
    .kv_wdata_i   (kv_wdata),
    .kv_raddr_a_i (kv_raddr_a),
    .kv_raddr_b_i (kv_raddr_b),
    .kv_rdata_a_o (kv_rdata_a),
    .kv_rdata_b_o (kv_rdata_b)
  );

  klp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  klp_ctrl #(
    .MAX_KEYS (MAX_KEYS),
    .CHANNELS (CHANNELS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .key_count_i  (key_count_q),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .s_item_i     (s_item),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_item_o     (m_item),
    .kt_we_o      (kt_we),
    .kt_waddr_o   (kt_waddr),
    .kt_wdata_o   (kt_wdata),
    .kt_raddr_o   (kt_raddr),
    .kt_rdata_i   (kt_rdata),
    .kv_we_o      (kv_we),
    .kv_waddr_o   (kv_waddr),
    .kv_wdata_o   (kv_wdata),
    .kv_raddr_a_o (kv_raddr_a),
    .kv_raddr_b_o (kv_raddr_b),
    .kv_rdata_a_i (kv_rdata_a),
    .kv_rdata_b_i (kv_rdata_b),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp)
  );

endmodule

// ===== hdl/klp_checker.sv =====
module klp_checker #(
  parameter int unsigned CHANNELS = klp_pkg::CHANNELS_DEF
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic [klp_pkg::OP_W-1:0]     s_axis_tuser,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [klp_pkg::M_DATA_W-1:0] m_axis_tdata,
  input logic                         m_axis_tlast
);
  import klp_pkg::*;

  // A start transaction completes at once, so the input is free again.
  a_start_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_START |=> s_axis_tready)
    else $error("input not ready after a start transaction");

  // A tick occupies the sequencer, so the input is not ready right after it.
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_TICK |=> !s_axis_tready)
    else $error("input ready straight after a tick transaction");

  // The final beat of a run carries the highest channel number.
  a_last_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[18:16] == 3'(CHANNELS - 1))
    else $error("tlast on a channel other than the last");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output transaction changed");

endmodule

bind keyframe_lerp_player klp_checker #(
  .CHANNELS (CHANNELS)
) u_klp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
